FILE: hdl/cfq_pkg.sv
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic op_en;
      logic rd_en;
   } cmd_type;

endpackage

FILE: hdl/cfq_ctrl.sv
// Controller state machine: request handshake, read sequencing, response valid.
module cfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   always_comb begin
      // a new request may enter while the current response leaves
      req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_SHOW) && !rsp_stall));
      req_accept = req_valid && !req_stall;
      cmd.op_en  = req_accept;
      cmd.rd_en  = (state_ff == ST_READ);
      rsp_valid  = rsp_valid_ff;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in     = ST_SHOW;
            rsp_valid_in = 1'b1;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = req_accept ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/cfq_dpath.sv
// Datapath: entry memory, head/tail/count registers and response fields.
module cfq_dpath #(
   parameter int DEPTH      = cfq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cfq_pkg::cmd_type  cmd,
   input  cfq_pkg::req_type  req_data,
   output cfq_pkg::rsp_type  rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];

   logic [AW-1:0]               head_ff, head_in;
   logic [AW-1:0]               tail_ff, tail_in;
   logic [AW-1:0]               last_ff, last_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [cfq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                        wr_en;
   logic signed [63:0]          value_ext;
   logic signed [DATA_WIDTH-1:0] rd_front_ff, rd_back_ff;
   logic signed [63:0]          front_ext, back_ext;
   logic [63:0]                 count_ext;
   logic                        is_full, is_empty;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
      logic [AW-1:0] res;
      if (idx == AW'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + AW'(1);
      end
      return res;
   endfunction

   always_comb begin
      is_full   = (count_ff == CW'(DEPTH));
      is_empty  = (count_ff == '0);
      value_ext = 64'(req_data.value);
      head_in   = head_ff;
      tail_in   = tail_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      status_in = cfq_pkg::STATUS_OK;
      wr_en     = 1'b0;
      case (req_data.func)
         cfq_pkg::FUNC_PUSH: begin
            if (is_full) begin
               status_in = cfq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               last_in  = tail_ff;
               tail_in  = wrap_inc(tail_ff);
               count_in = count_ff + CW'(1);
            end
         end
         cfq_pkg::FUNC_POP: begin
            if (is_empty) begin
               status_in = cfq_pkg::STATUS_EMPTY;
            end else begin
               head_in  = wrap_inc(head_ff);
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            // peek, and the unused code behaves the same
            if (is_empty) begin
               status_in = cfq_pkg::STATUS_EMPTY;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.op_en) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_en) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_en && wr_en) begin
         mem_ff[tail_ff] <= value_ext[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_front_ff <= mem_ff[head_ff];
         rd_back_ff  <= mem_ff[last_ff];
      end
   end

   always_comb begin
      front_ext = 64'(rd_front_ff);
      back_ext  = 64'(rd_back_ff);
      count_ext = 64'(count_ff);
      rsp_data.status      = status_ff;
      rsp_data.front_value = is_empty ? '0 : front_ext[cfq_pkg::VALUE_W-1:0];
      rsp_data.back_value  = is_empty ? '0 : back_ext[cfq_pkg::VALUE_W-1:0];
      rsp_data.count       = count_ext[cfq_pkg::COUNT_W-1:0];
   end

endmodule

FILE: hdl/circular_fifo_queue_top.sv
// Circular FIFO queue of signed words: controller and datapath.
//
// Each request pushes a word, pops the oldest entry or peeks; every request returns
// one response with a status, the oldest and newest entries after the operation
// (zero when the queue is empty) and the entry count. A push onto a full queue is
// dropped with a full status; a pop or peek on an empty queue reports empty.
// A request runs through the READ and SHOW states: the operation updates the pointers
// and writes the entry memory at acceptance, then the READ state reads the oldest and
// newest entries through the memory's registered read ports, and the SHOW state holds
// the response. The next request is taken in the cycle the response leaves, so a new
// request is never accepted while an earlier one is still in flight. The memory needs
// no clearing after reset; only entries that were written are ever shown.
module circular_fifo_queue_top #(
   parameter int DEPTH      = cfq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cfq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfq_pkg::rsp_type  rsp_data
);

   cfq_pkg::cmd_type cmd;

   cfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cfq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: bench/circular_fifo_queue_top_tb.sv
// Self-checking bench for the circular FIFO queue: directed table, then random traffic.
module circular_fifo_queue_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 11;
   localparam int DEPTH        = cfq_pkg::DEPTH_DEFAULT;
   localparam int DATA_W       = cfq_pkg::DATA_WIDTH_DEFAULT;
   localparam int RANDOM_REQS  = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam longint TIMEOUT_NS = 4_000_000;

   // opcode the block treats as a peek
   localparam logic [cfq_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      cfq_pkg::req_type req;
      bit               typed;
      cfq_pkg::rsp_type exp;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cfq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   cfq_pkg::rsp_type rsp_data;

   // shadow copy of the queue
   logic [DATA_W-1:0]           shadow_words [DEPTH];
   int                          shadow_head;
   int                          shadow_tail;
   logic [cfq_pkg::COUNT_W-1:0] shadow_fill;

   cfq_pkg::rsp_type pending_rsp_q [$];
   plan_row_type     directed_plan [$];

   int sent_total;
   int rsp_checked;
   int mismatch_total;
   int full_drops;
   int empty_errors;
   int burst_left;

   circular_fifo_queue_top #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d responses still outstanding", pending_rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Applies one request to the shadow queue and returns the response it should produce.
   function automatic cfq_pkg::rsp_type fifo_predict(input cfq_pkg::req_type r);
      cfq_pkg::rsp_type res;
      res.status = cfq_pkg::STATUS_OK;
      case (r.func)
         cfq_pkg::FUNC_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = cfq_pkg::STATUS_FULL;
            end else begin
               shadow_words[shadow_tail] = r.value[DATA_W-1:0];
               shadow_tail = (shadow_tail + 1) % DEPTH;
               shadow_fill = shadow_fill + 1'b1;
            end
         end
         cfq_pkg::FUNC_POP: begin
            if (shadow_fill == 0) begin
               res.status = cfq_pkg::STATUS_EMPTY;
            end else begin
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_fill = shadow_fill - 1'b1;
            end
         end
         default: begin
            if (shadow_fill == 0) res.status = cfq_pkg::STATUS_EMPTY;
         end
      endcase
      if (shadow_fill == 0) begin
         res.front_value = '0;
         res.back_value  = '0;
      end else begin
         res.front_value = cfq_pkg::VALUE_W'(signed'(shadow_words[shadow_head]));
         res.back_value  = cfq_pkg::VALUE_W'(
                              signed'(shadow_words[(shadow_tail + DEPTH - 1) % DEPTH]));
      end
      res.count = shadow_fill;
      return res;
   endfunction

   task automatic add_row(input logic [cfq_pkg::FUNC_W-1:0] func,
                          input logic [cfq_pkg::VALUE_W-1:0] value,
                          input bit typed, input cfq_pkg::status_type st,
                          input logic [cfq_pkg::VALUE_W-1:0] front,
                          input logic [cfq_pkg::VALUE_W-1:0] back,
                          input logic [cfq_pkg::COUNT_W-1:0] cnt);
      plan_row_type row;
      row.req.func          = func;
      row.req.value         = value;
      row.typed             = typed;
      row.exp.status        = st;
      row.exp.front_value   = front;
      row.exp.back_value    = back;
      row.exp.count         = cnt;
      directed_plan.push_back(row);
   endtask

   // Offers one request in the sender's burst pattern; returns at the falling edge after
   // acceptance. Typed rows queue their hand-written response instead of the prediction.
   task automatic drive_request(input cfq_pkg::req_type r, input bit typed,
                                input cfq_pkg::rsp_type typed_rsp);
      cfq_pkg::rsp_type predicted;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = fifo_predict(r);
      if (predicted.status == cfq_pkg::STATUS_FULL) full_drops++;
      if (predicted.status == cfq_pkg::STATUS_EMPTY) empty_errors++;
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      sent_total++;
      @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      cfq_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_checked++;
         if (pending_rsp_q.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= MAX_REPORTS)
               $display("unexpected response: status=%0d front=%0d back=%0d count=%0d",
                        rsp_data.status, rsp_data.front_value, rsp_data.back_value,
                        rsp_data.count);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.front_value !== want.front_value
                || rsp_data.back_value !== want.back_value
                || rsp_data.count !== want.count) begin
               mismatch_total++;
               if (mismatch_total <= MAX_REPORTS)
                  $display({"mismatch at response %0d: ",
                            "exp status=%0d front=%0d back=%0d count=%0d, ",
                            "got status=%0d front=%0d back=%0d count=%0d"},
                           rsp_checked, want.status, want.front_value, want.back_value,
                           want.count, rsp_data.status, rsp_data.front_value,
                           rsp_data.back_value, rsp_data.count);
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off so the queue backs up
   initial begin : rsp_stall_gen
      int mode;
      int span;
      int hold;
      int step;
      bit held_off;
      held_off  = 1'b0;
      step      = 0;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 9);
         span = (mode == 9) ? $urandom_range(1, 8) : $urandom_range(5, 40);
         if (!held_off && rsp_checked >= 120) begin
            held_off = 1'b1;
            for (hold = 0; hold < HOLD_CYCLES; hold++) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         repeat (span) begin
            @(negedge clock);
            step++;
            if (mode < 3) rsp_stall <= 1'b0;
            else if (mode < 6) rsp_stall <= ($urandom_range(0, 99) < 40);
            else if (mode < 9) rsp_stall <= (step % 3 == 0);
            else rsp_stall <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      cfq_pkg::req_type r;
      cfq_pkg::rsp_type no_rsp;
      int push_pct;
      int seg_len;
      int roll;
      int i;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      no_rsp    = '0;
      shadow_head = 0;
      shadow_tail = 0;
      shadow_fill = '0;
      for (i = 0; i < DEPTH; i++) shadow_words[i] = '0;
      sent_total = 0;
      rsp_checked = 0;
      mismatch_total = 0;
      full_drops = 0;
      empty_errors = 0;
      burst_left = 0;

      // empty queue errors, extremes, spare opcode, then fill across the wrap and overflow
      add_row(cfq_pkg::FUNC_POP,  32'h0000_0000, 1, cfq_pkg::STATUS_EMPTY,
              32'h0, 32'h0, 5'd0);
      add_row(cfq_pkg::FUNC_PEEK, 32'hFFFF_FFFF, 1, cfq_pkg::STATUS_EMPTY,
              32'h0, 32'h0, 5'd0);
      add_row(FUNC_SPARE,         32'h1234_5678, 1, cfq_pkg::STATUS_EMPTY,
              32'h0, 32'h0, 5'd0);
      add_row(cfq_pkg::FUNC_PUSH, 32'h8000_0000, 1, cfq_pkg::STATUS_OK,
              32'h8000_0000, 32'h8000_0000, 5'd1);
      add_row(cfq_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 1, cfq_pkg::STATUS_OK,
              32'h8000_0000, 32'h7FFF_FFFF, 5'd2);
      add_row(cfq_pkg::FUNC_PEEK, 32'h0000_0000, 1, cfq_pkg::STATUS_OK,
              32'h8000_0000, 32'h7FFF_FFFF, 5'd2);
      add_row(FUNC_SPARE,         32'hFFFF_FFFF, 1, cfq_pkg::STATUS_OK,
              32'h8000_0000, 32'h7FFF_FFFF, 5'd2);
      add_row(cfq_pkg::FUNC_POP,  32'h0000_0000, 1, cfq_pkg::STATUS_OK,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1);
      add_row(cfq_pkg::FUNC_POP,  32'h0000_0000, 1, cfq_pkg::STATUS_OK,
              32'h0, 32'h0, 5'd0);
      for (i = 0; i < DEPTH; i++)
         add_row(cfq_pkg::FUNC_PUSH,
                 (i == 0) ? 32'h5555_5555 : (i == 1) ? 32'hAAAA_AAAA : $urandom,
                 0, cfq_pkg::STATUS_OK, 32'h0, 32'h0, 5'd0);
      add_row(cfq_pkg::FUNC_PUSH, 32'hDEAD_BEEF, 0, cfq_pkg::STATUS_FULL,
              32'h0, 32'h0, 5'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[k])
         drive_request(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].exp);

      // random traffic in segments that lean toward filling, draining or neither
      i = 0;
      while (i < RANDOM_REQS) begin
         case ($urandom_range(0, 3))
            0: push_pct = 85;
            1: push_pct = 15;
            2: push_pct = 50;
            default: push_pct = 65;
         endcase
         seg_len = $urandom_range(8, 40);
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) r.func = FUNC_SPARE;
            else if (roll < 15) r.func = cfq_pkg::FUNC_PEEK;
            else if ($urandom_range(0, 99) < push_pct) r.func = cfq_pkg::FUNC_PUSH;
            else r.func = cfq_pkg::FUNC_POP;
            case ($urandom_range(0, 19))
               0: r.value = 32'h8000_0000;
               1: r.value = 32'h7FFF_FFFF;
               2: r.value = 32'h0000_0000;
               3: r.value = 32'hFFFF_FFFF;
               default: r.value = $urandom;
            endcase
            drive_request(r, 0, no_rsp);
            i++;
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent (%0d from the directed table), %0d responses checked",
               sent_total, directed_plan.size(), rsp_checked);
      $display("%0d pushes dropped on a full queue, %0d pops/peeks on an empty queue",
               full_drops, empty_errors);
      if (mismatch_total == 0 && pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_total,
                  pending_rsp_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
